### hw/rtl/fdli_pkg.sv
// ----------------------------------------------------------------------------
// fdli_pkg: shared types and constants of the feedback delay line
// Fixed-point constants, register indexes, the store control word and the
// 16-bit saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdli_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] REG_SMOOTH      = 2'd1;
  localparam logic [1:0] REG_MODE        = 2'd2;

  // Reset values of the registers
  localparam logic [17:0] SAMPLE_RATE_RST = 18'd48000;
  localparam logic [15:0] SMOOTH_RST      = 16'd262;

  // Chorus target: 3 ms + 2 ms * modulation, seconds in Q1.31
  localparam logic signed [33:0] CHORUS_BASE = 34'sd6442451;
  localparam logic signed [33:0] CHORUS_SPAN = 34'sd4294967;

  // Feedback scale 0.95 in Q0.16
  localparam logic signed [18:0] FB_SCALE = 19'sd62259;

  // 1.0 in Q0.16
  localparam logic [16:0] UNITY = 17'd65536;

  // Integer part of the delay in samples: 32 + 18 - 15 - 16 bits
  localparam int DINT_W = 19;

  // Store control word
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -36'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/feedback_delay_line_interp.sv
// ----------------------------------------------------------------------------
// feedback_delay_line_interp: fractional delay line with feedback
// Smoothed delay time, linear interpolation between two stored samples,
// feedback write-back and dry/wet mix, all on one shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: the taken word runs through the steps in order, among them NSTEPS
//   reduction steps (NSTEPS = 3 at the default depth).
// Flow: no new word is taken before the result enters the output register;
//   in_stall_o is high outside idle; the final step waits for a free output.
// Reset: registers return to their defaults and the store reads as all zero at
//   once; a fill pointer masks unwritten entries, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module feedback_delay_line_interp #(
  parameter int BUFFER_DEPTH = 131072
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] audio_in_i,
  input  wire logic [23:0]        delay_time_i,
  input  wire logic [15:0]        feedback_i,
  input  wire logic [16:0]        wet_mix_i,
  input  wire logic signed [15:0] modulation_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      audio_out_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Address width of the store and the modulo reduction schedule. The integer
  // delay is below 2^DINT_W, so NSTEPS conditional subtracts of shifted copies
  // of the depth bring it below the depth.
  localparam int AW     = $clog2(BUFFER_DEPTH);
  localparam int DINT_W = fdli_pkg::DINT_W;
  localparam int NRED   = DINT_W - AW + 1;
  localparam int NSTEPS = (NRED < 1) ? 1 : NRED;
  localparam int CNT_W  = $clog2(NSTEPS + 1);
  localparam int SW     = (AW + 1 > DINT_W + 1) ? AW + 1 : DINT_W + 1;
  localparam logic [SW-1:0] DIV_INIT = SW'(BUFFER_DEPTH) << (NSTEPS - 1);
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(BUFFER_DEPTH);

  // Sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHOR = 4'd1;   // chorus offset product
  localparam logic [3:0] S_DIFF = 4'd2;   // target minus smoothed time
  localparam logic [3:0] S_SMUL = 4'd3;   // coeff * difference
  localparam logic [3:0] S_UPD  = 4'd4;   // update smoothed time
  localparam logic [3:0] S_RMUL = 4'd5;   // time * sample rate
  localparam logic [3:0] S_DLY  = 4'd6;   // split delay into integer / fraction
  localparam logic [3:0] S_RED  = 4'd7;   // integer delay modulo depth
  localparam logic [3:0] S_POS  = 4'd8;   // read position
  localparam logic [3:0] S_RD1  = 4'd9;   // read newer neighbor
  localparam logic [3:0] S_RD0  = 4'd10;  // read older neighbor
  localparam logic [3:0] S_WR   = 4'd11;  // write back, interpolation product
  localparam logic [3:0] S_TAP  = 4'd12;  // form tap, dry product
  localparam logic [3:0] S_MIX1 = 4'd13;  // wet product
  localparam logic [3:0] S_MIX2 = 4'd14;  // sum and present result

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [17:0] rate_q;
  logic [15:0] coeff_q;
  logic        mode_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= fdli_pkg::SAMPLE_RATE_RST;
      coeff_q <= fdli_pkg::SMOOTH_RST;
      mode_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        fdli_pkg::REG_SAMPLE_RATE: rate_q  <= pwdata[17:0];
        fdli_pkg::REG_SMOOTH:      coeff_q <= pwdata[15:0];
        fdli_pkg::REG_MODE:        mode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fdli_pkg::REG_SAMPLE_RATE: prdata = {14'd0, rate_q};
      fdli_pkg::REG_SMOOTH:      prdata = {16'd0, coeff_q};
      fdli_pkg::REG_MODE:        prdata = {31'd0, mode_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer, input capture and datapath registers
  // --------------------------------------------------------------------------
  logic [3:0]         state_q, state_d;
  logic               in_acc;
  logic               out_free;

  logic signed [15:0] audio_q;
  logic [23:0]        dtime_q;
  logic [15:0]        fb_q;
  logic [16:0]        wet_q;       // saturated to unity on capture
  logic signed [15:0] mod_q;

  logic [31:0]        s_q;         // smoothed time, Q1.31 seconds
  logic signed [15:0] last_tap_q;
  logic signed [33:0] diff_q;
  logic [15:0]        fbm_q;
  logic signed [15:0] wdata_q;
  logic [DINT_W-1:0]  rem_q;
  logic [SW-1:0]      div_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [15:0]        frac_q;
  logic [AW-1:0]      i1_q;
  logic signed [15:0] y1_q;
  logic signed [15:0] y0_q;
  logic signed [15:0] tap_q;
  logic signed [33:0] acc_q;
  logic               out_valid_q;
  logic signed [15:0] out_q;

  // Shared multiplier, product registered every cycle
  logic signed [33:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [52:0] prod_q;

  // Store interface
  fdli_pkg::mem_ctl_t st_ctl;
  logic [AW-1:0]      st_raddr;
  logic signed [15:0] st_rdata;
  logic [AW-1:0]      st_wptr;

  // Combinational helpers
  logic signed [33:0] tgt;
  logic signed [33:0] diff_d;
  logic [SW-1:0]      rem_ext;
  logic [AW:0]        p_sum;
  logic [AW:0]        p_mod;
  logic [AW-1:0]      p0;
  logic [AW-1:0]      p1;
  logic [AW-1:0]      i0;
  logic signed [16:0] ydiff;
  logic [15:0]        t_w;
  logic signed [16:0] tap_w;
  logic [16:0]        dry;
  logic signed [33:0] mix_sum;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Delay target: modulated chorus time or the requested delay time
  assign tgt    = mode_q ? (fdli_pkg::CHORUS_BASE + 34'(prod_q >>> 15))
                         : $signed({2'b00, dtime_q, 8'h00});
  assign diff_d = tgt - $signed({2'b00, s_q});

  // Read position: write pointer minus the integer delay, modulo depth; one
  // more step back when there is a fractional part
  assign rem_ext = SW'(rem_q);
  assign p_sum   = (AW + 1)'(st_wptr) + DEPTH_X - (AW + 1)'(rem_q);
  assign p_mod   = (p_sum >= DEPTH_X) ? (p_sum - DEPTH_X) : p_sum;
  assign p0      = AW'(p_mod);
  assign p1      = (frac_q == 16'd0) ? p0
                 : ((p0 == '0) ? AW'(BUFFER_DEPTH - 1) : p0 - 1'b1);
  assign i0      = (i1_q == '0) ? AW'(BUFFER_DEPTH - 1) : i1_q - 1'b1;

  // Interpolation weight toward the newer entry: 1 - frac, or 0 at frac 0
  assign t_w     = 16'(-frac_q);
  assign ydiff   = 17'(y1_q) - 17'(st_rdata);
  assign tap_w   = 17'(y0_q) + 17'(prod_q >>> 16);
  assign dry     = fdli_pkg::UNITY - wet_q;
  assign mix_sum = acc_q + 34'(prod_q);

  // Multiplier operands and store control per step
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    st_ctl   = '0;
    st_raddr = i1_q;
    case (state_q)
      S_CHOR: begin
        mul_a = fdli_pkg::CHORUS_SPAN;
        mul_b = 19'(mod_q);
      end
      S_DIFF: begin
        mul_a = $signed({18'd0, fb_q});
        mul_b = fdli_pkg::FB_SCALE;
      end
      S_SMUL: begin
        mul_a = diff_q;
        mul_b = $signed({3'd0, coeff_q});
      end
      S_UPD: begin
        mul_a = 34'(last_tap_q);
        mul_b = $signed({3'd0, fbm_q});
      end
      S_RMUL: begin
        mul_a = $signed({2'b00, s_q});
        mul_b = $signed({1'b0, rate_q});
      end
      S_RD1: begin
        st_ctl.rd = 1'b1;
        st_raddr  = i1_q;
      end
      S_RD0: begin
        st_ctl.rd = 1'b1;
        st_raddr  = i0;
      end
      S_WR: begin
        st_ctl.wr = 1'b1;
        mul_a     = 34'(ydiff);
        mul_b     = $signed({3'd0, t_w});
      end
      S_TAP: begin
        mul_a = 34'(audio_q);
        mul_b = $signed({2'b00, dry});
      end
      // Hold the wet product while the result waits for the output register
      S_MIX1, S_MIX2: begin
        mul_a = 34'(tap_q);
        mul_b = $signed({2'b00, wet_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Next step
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_CHOR;
      S_CHOR: state_d = S_DIFF;
      S_DIFF: state_d = S_SMUL;
      S_SMUL: state_d = S_UPD;
      S_UPD:  state_d = S_RMUL;
      S_RMUL: state_d = S_DLY;
      S_DLY:  state_d = S_RED;
      S_RED:  if (cnt_q == '0) state_d = S_POS;
      S_POS:  state_d = S_RD1;
      S_RD1:  state_d = S_RD0;
      S_RD0:  state_d = S_WR;
      S_WR:   state_d = S_TAP;
      S_TAP:  state_d = S_MIX1;
      S_MIX1: state_d = S_MIX2;
      S_MIX2: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and the model state that reset clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      s_q         <= '0;
      last_tap_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_MIX2 && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_UPD) begin
        s_q <= s_q + 32'(prod_q >>> 16);
      end
      if (state_q == S_TAP) begin
        last_tap_q <= fdli_pkg::sat16(36'(tap_w));
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      audio_q <= audio_in_i;
      dtime_q <= delay_time_i;
      fb_q    <= feedback_i;
      wet_q   <= (wet_mix_i > fdli_pkg::UNITY) ? fdli_pkg::UNITY : wet_mix_i;
      mod_q   <= modulation_i;
    end
    case (state_q)
      S_DIFF: diff_q <= diff_d;
      S_SMUL: fbm_q  <= prod_q[31:16];
      S_RMUL: wdata_q <= fdli_pkg::sat16(36'(audio_q) + 36'(prod_q >>> 16));
      S_DLY: begin
        // delay in samples, Q.16: product >> 15
        rem_q  <= prod_q[49:31];
        frac_q <= prod_q[30:15];
        div_q  <= DIV_INIT;
        cnt_q  <= CNT_W'(NSTEPS - 1);
      end
      S_RED: begin
        if (rem_ext >= div_q) begin
          rem_q <= DINT_W'(rem_ext - div_q);
        end
        div_q <= div_q >> 1;
        cnt_q <= cnt_q - 1'b1;
      end
      S_POS:  i1_q <= p1;
      S_RD0:  y1_q <= st_rdata;
      S_WR:   y0_q <= st_rdata;
      S_TAP:  tap_q <= fdli_pkg::sat16(36'(tap_w));
      S_MIX1: acc_q <= 34'(prod_q);
      S_MIX2: begin
        if (out_free) begin
          out_q <= fdli_pkg::sat16(36'(mix_sum >>> 16));
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign audio_out_o = out_q;

  // --------------------------------------------------------------------------
  // Sample store
  // --------------------------------------------------------------------------
  fdli_store #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (st_ctl),
    .raddr_i (st_raddr),
    .wdata_i (wdata_q),
    .rdata_o (st_rdata),
    .wptr_o  (st_wptr)
  );

`ifndef NO_ASSERTIONS
  a_out_from_mix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_MIX2))
    else $error("result word raised outside the final step");

  a_rem_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POS) |-> (SW'(rem_q) < SW'(BUFFER_DEPTH)))
    else $error("integer delay not reduced below depth");

  a_rd_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD1) |-> ((AW + 1)'(i1_q) < DEPTH_X))
    else $error("read index beyond store depth");

  a_tap_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_tap_q) |-> $past(state_q == S_TAP))
    else $error("feedback tap changed outside the tap step");
`endif

endmodule

`default_nettype wire

### hw/rtl/fdli_store.sv
// ----------------------------------------------------------------------------
// fdli_store: circular sample store with fill tracking
// Single-port memory written at an internal write pointer; entries never
// written since reset read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdli_store #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fdli_pkg::mem_ctl_t ctl_i,
  input  wire logic [AW-1:0]      raddr_i,
  input  wire logic [15:0]        wdata_i,
  output logic [15:0]             rdata_o,
  output logic [AW-1:0]           wptr_o
);

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata_q;
  logic          rvalid_q;
  logic [AW-1:0] wp_q;
  logic          wrapped_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wp_q] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q  <= mem[raddr_i];
      rvalid_q <= wrapped_q || (raddr_i < wp_q);
    end
  end

  // Write pointer and the flag that marks the first full pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (ctl_i.wr) begin
      if (wp_q == AW'(DEPTH - 1)) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : 16'h0000;
  assign wptr_o  = wp_q;

`ifndef NO_ASSERTIONS
  a_single_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.rd && ctl_i.wr))
    else $error("store read and write in the same cycle");

  a_wp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AW + 1)'(wp_q) < (AW + 1)'(DEPTH))
    else $error("write pointer beyond store depth");

  a_wrap_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(wrapped_q))
    else $error("fill flag dropped without reset");
`endif

endmodule

`default_nettype wire

### sim/tb_feedback_delay_line_interp.sv
// ----------------------------------------------------------------------------
// tb_feedback_delay_line_interp: self-checking bench of the feedback delay line
// Streams audio words through the block under random sender gaps and receiver
// stalls, re-programs the registers between phases and checks every
// audio_out word against a bit-exact predictor of the delay line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_feedback_delay_line_interp;

  localparam int LINE_DEPTH    = 131072;
  localparam int SETTLE_CYCLES = 40;          // settle margin after the queues drain
  localparam longint CHORUS_CENTER = 6442451; // 3 ms in Q1.31
  localparam longint CHORUS_SWING  = 4294967; // 2 ms in Q1.31
  localparam longint FB_CEILING    = 62259;   // 0.95 in Q0.16

  // One input word as the sender sees it
  typedef struct packed {
    logic signed [15:0] audio;
    logic [23:0]        dtime;
    logic [15:0]        fb;
    logic [16:0]        wet;
    logic signed [15:0] modv;
  } sample_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic signed [15:0]  audio_in_i = '0;
  logic [23:0]         delay_time_i = '0;
  logic [15:0]         feedback_i = '0;
  logic [16:0]         wet_mix_i = '0;
  logic signed [15:0]  modulation_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [15:0]  audio_out_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  feedback_delay_line_interp dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .audio_in_i   (audio_in_i),
    .delay_time_i (delay_time_i),
    .feedback_i   (feedback_i),
    .wet_mix_i    (wet_mix_i),
    .modulation_i (modulation_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .audio_out_o  (audio_out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Delay line predictor: private copy of the registers and the line state
  // --------------------------------------------------------------------------
  logic [17:0] cfg_rate  = 18'd48000;
  logic [15:0] cfg_coeff = 16'd262;
  logic        cfg_mode  = 1'b0;

  shortint     line_mem [LINE_DEPTH];  // two-state, so it starts all zero
  int          line_wptr = 0;
  logic [31:0] line_smooth = '0;
  shortint     line_last_tap = 0;

  sample_word_t       pending_words[$];   // words still to be sent
  logic signed [15:0] expected_audio[$];  // predicted audio_out, oldest first

  int mismatches   = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int settings_run = 1;
  int calm_left    = 0;  // while nonzero neither side starts a new pause
  logic [23:0] dtime_hold = '0;

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  // Advance the line by one sample and return the audio_out it must produce.
  function automatic logic signed [15:0] advance_delay_line(input sample_word_t w);
    longint target, s, dly, dint, frac, pos, i0, i1, t, y0, y1, tap, fbm, wet, mix;
    // Pick the target time: delay mode follows the input, chorus swings 1..5 ms
    if (cfg_mode)
      target = CHORUS_CENTER + ((CHORUS_SWING * longint'($signed(w.modv))) >>> 15);
    else
      target = longint'(w.dtime) << 8;
    // One-pole smoothing toward the target, floor division throughout
    s = longint'(line_smooth);
    s = s + ((longint'(cfg_coeff) * (target - s)) >>> 16);
    line_smooth = s[31:0];
    // Delay in samples, Q.16
    dly  = (longint'(line_smooth) * longint'(cfg_rate)) >> 15;
    dint = dly >> 16;
    frac = dly & 64'hffff;
    // Read position behind the write pointer, wrapped into the line
    pos = (longint'(line_wptr) + LINE_DEPTH - (dint % LINE_DEPTH)) % LINE_DEPTH;
    if (frac != 0) pos = (pos + LINE_DEPTH - 1) % LINE_DEPTH;
    i1 = pos;
    i0 = (pos + LINE_DEPTH - 1) % LINE_DEPTH;
    t  = (frac != 0) ? 65536 - frac : 0;
    y0 = line_mem[i0];
    y1 = line_mem[i1];
    tap = y0 + ((t * (y1 - y0)) >>> 16);
    // Write back input plus scaled feedback of the previous tap
    fbm = (longint'(w.fb) * FB_CEILING) >> 16;
    line_mem[line_wptr] = clamp16(longint'($signed(w.audio)) +
                                  ((longint'(line_last_tap) * fbm) >>> 16));
    line_last_tap = clamp16(tap);
    // Dry/wet mix, wet clipped at unity
    wet = (w.wet > 17'd65536) ? 65536 : longint'(w.wet);
    mix = longint'($signed(w.audio)) * (65536 - wet) + tap * wet;
    line_wptr = (line_wptr + 1) % LINE_DEPTH;
    return clamp16(mix >>> 16);
  endfunction

  // Often no pause, often a short one, sometimes a longer one, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm_left > 0 || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 24);
    return $urandom_range(25, 120);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: drive words from the pending queue, predict each accepted word
  // --------------------------------------------------------------------------
  sample_word_t on_wire;
  int           send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid_i;
      // Predict the word the block takes at this edge
      if (in_valid_i && !in_stall_o) begin
        expected_audio.push_back(advance_delay_line(on_wire));
        words_sent++;
        next_valid = 1'b0;
      end
      // Hold off for the gap, then present the next word
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() != 0) begin
          on_wire = pending_words.pop_front();
          audio_in_i   <= on_wire.audio;
          delay_time_i <= on_wire.dtime;
          feedback_i   <= on_wire.fb;
          wet_mix_i    <= on_wire.wet;
          modulation_i <= on_wire.modv;
          next_valid = 1'b1;
          send_gap = pick_pause();
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, compare every accepted word with the oldest
  // prediction
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : check_words
    logic signed [15:0] want;
    int n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_audio.size() == 0) begin
          $error("audio_out: expected nothing, got %0d", audio_out_o);
          mismatches++;
        end else begin
          want = expected_audio.pop_front();
          results_seen++;
          if (audio_out_o !== want) begin
            $error("audio_out: expected %0d, got %0d", want, audio_out_o);
            mismatches++;
          end
        end
      end
      // Open a quiet stretch now and then so both sides run back to back
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 499) == 0) calm_left = $urandom_range(100, 400);
      n = 0;
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        if ($urandom_range(0, 7) == 0) n = pick_pause();
        stall_left = (n > 0) ? n - 1 : 0;
        out_stall_i <= (n > 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and stimulus
  // --------------------------------------------------------------------------
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      fdli_pkg::REG_SAMPLE_RATE: cfg_rate  = val[17:0];
      fdli_pkg::REG_SMOOTH:      cfg_coeff = val[15:0];
      fdli_pkg::REG_MODE:        cfg_mode  = val[0];
      default: ;
    endcase
  endtask

  // Wait until the line is empty and every prediction has been matched
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_audio.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reconfigure(input int rate, input int coeff, input bit chorus);
    wait_drained();
    reg_write(fdli_pkg::REG_SAMPLE_RATE, rate);
    reg_write(fdli_pkg::REG_SMOOTH, coeff);
    reg_write(fdli_pkg::REG_MODE, {31'd0, chorus});
    settings_run++;
    @(negedge clk_i);
  endtask

  task automatic push_word(input int audio, input int dtime, input int fb,
                           input int wet, input int modv);
    sample_word_t w;
    w.audio = audio[15:0];
    w.dtime = dtime[23:0];
    w.fb    = fb[15:0];
    w.wet   = wet[16:0];
    w.modv  = modv[15:0];
    pending_words.push_back(w);
  endtask

  // Random words; short delays keep reads on freshly written samples
  task automatic fill_random(input int count, input bit long_delays);
    sample_word_t w;
    int r;
    dtime_hold = long_delays ? 24'($urandom) : 24'($urandom_range(0, 12000));
    repeat (count) begin
      r = $urandom_range(0, 9);
      w.audio = (r == 0) ? 16'sh7fff : (r == 1) ? -16'sh8000 : 16'($urandom);
      r = $urandom_range(0, 19);
      if (r < 14) w.dtime = dtime_hold;
      else if (r < 18 && !long_delays) w.dtime = 24'($urandom_range(0, 12000));
      else w.dtime = 24'($urandom);
      if (r == 19) dtime_hold = w.dtime;
      r = $urandom_range(0, 9);
      w.fb = (r == 0) ? 16'hffff : (r == 1) ? 16'h0000 : 16'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) w.wet = 17'd0;
      else if (r == 1) w.wet = 17'd65536;
      else if (r == 2) w.wet = 17'($urandom_range(65537, 131071));
      else w.wet = 17'($urandom_range(0, 65536));
      w.modv = 16'($urandom);
      pending_words.push_back(w);
    end
  endtask

  initial begin : run_test
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes at the reset settings
    push_word(0, 0, 0, 0, 0);
    push_word(32767, 24'hffffff, 65535, 65536, 32767);
    push_word(-32768, 24'hffffff, 65535, 131071, -32768);
    push_word(-32768, 0, 0, 0, 0);

    // Directed: one-sample delay with full feedback drives the store into clipping
    reconfigure(8000, 65535, 1'b0);
    repeat (3) push_word(32767, 1049, 65535, 65536, 0);
    repeat (2) push_word(-32768, 1049, 65535, 65537, 0);
    push_word(32767, 1049, 0, 32768, 0);
    // Zero delay: the smoother settles on the target, then reads the write slot
    repeat (3) push_word(12345, 0, 32768, 65536, 0);
    push_word(-1, 24'hffffff, 65535, 65536, 0);

    // Directed: delay longer than the line wraps around it
    reconfigure(192000, 65535, 1'b0);
    repeat (3) push_word(20000, 24'hffffff, 65535, 65536, 0);

    // Directed: chorus at both ends of the modulation swing
    reconfigure(48000, 65535, 1'b1);
    push_word(32767, 0, 65535, 65536, 32767);
    push_word(-32768, 24'hffffff, 65535, 0, -32768);
    push_word(100, 0, 0, 131071, 0);

    // Random phases; each boundary drains the block before re-programming
    reconfigure(8000, 65535, 1'b0);   fill_random(220, 1'b0);
    reconfigure(48000, 262, 1'b1);    fill_random(220, 1'b0);
    reconfigure(192000, 30000, 1'b0); fill_random(180, 1'b1);
    reconfigure(0, 4000, 1'b0);       fill_random(120, 1'b0);
    reconfigure(262143, 0, 1'b1);     fill_random(120, 1'b0);
    reconfigure(16000, 20000, 1'b1);  fill_random(220, 1'b0);
    reconfigure(44100, 65535, 1'b0);  fill_random(220, 1'b0);
    reconfigure(96000, 1000, 1'b0);   fill_random(180, 1'b1);

    wait_drained();
    $display("tb: %0d words sent, %0d results checked over %0d register settings",
             words_sent, results_seen, settings_run);
    $display("tb: delay and chorus modes, zero and out-of-range delays, wet above unity");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #(64'd30_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
hw/rtl/fdli_pkg.sv
hw/rtl/fdli_store.sv
hw/rtl/feedback_delay_line_interp.sv
sim/tb_feedback_delay_line_interp.sv
